// ===== hdl/qad_pkg.sv =====
// Shared widths and payload types for the quadrilateral area pipeline.
// Used by every module of the block; depends on nothing else.
package qad_pkg;

    // Coordinate and intermediate widths. Each width is derived from COORD_W or from a width above it.
    localparam int COORD_W  = 16;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int CROSS_W  = PROD_W + 1;
    // |a x b| per component stays below 2^(2*COORD_W+1), so this is exact.
    localparam int MAG_W    = 2 * COORD_W + 1;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int ROOT_W   = MAG_W + 1;
    localparam int SUM_W    = 2 * ROOT_W;
    localparam int REM_W    = ROOT_W + 1;
    localparam int OUT_W    = ROOT_W - 1;

    localparam int IN_TDATA_W  = 12 * COORD_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [CROSS_W-1:0] cross_comp_t;

    // First member sits in the highest bits, so x lands lowest.
    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } point_t;

    typedef struct packed {
        point_t second_end;
        point_t second_start;
        point_t first_end;
        point_t first_start;
    } quad_t;

    typedef struct packed {
        diff_t z;
        diff_t y;
        diff_t x;
    } dvec_t;

    typedef struct packed {
        prod_t yz;
        prod_t zy;
        prod_t zx;
        prod_t xz;
        prod_t xy;
        prod_t yx;
    } prods_t;

    typedef struct packed {
        cross_comp_t z;
        cross_comp_t y;
        cross_comp_t x;
    } cross_t;

endpackage

// ===== hdl/qad_cross.sv =====
// Three-stage cross product: diagonal vectors, partial products, component differences.
// Depends on qad_pkg for widths and payload types.
module qad_cross (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  qad_pkg::quad_t  in_quad,
    output logic            out_valid,
    output qad_pkg::cross_t out_cross
);

    qad_pkg::dvec_t  a_reg, b_reg, a_next, b_next;
    qad_pkg::prods_t prod_reg, prod_next;
    qad_pkg::cross_t cross_reg, cross_next;
    logic [2:0]      vld_reg;

    always_comb begin
        a_next.x = qad_pkg::DIFF_W'(in_quad.first_start.x) - qad_pkg::DIFF_W'(in_quad.first_end.x);
        a_next.y = qad_pkg::DIFF_W'(in_quad.first_start.y) - qad_pkg::DIFF_W'(in_quad.first_end.y);
        a_next.z = qad_pkg::DIFF_W'(in_quad.first_start.z) - qad_pkg::DIFF_W'(in_quad.first_end.z);
        b_next.x = qad_pkg::DIFF_W'(in_quad.second_start.x)
                 - qad_pkg::DIFF_W'(in_quad.second_end.x);
        b_next.y = qad_pkg::DIFF_W'(in_quad.second_start.y)
                 - qad_pkg::DIFF_W'(in_quad.second_end.y);
        b_next.z = qad_pkg::DIFF_W'(in_quad.second_start.z)
                 - qad_pkg::DIFF_W'(in_quad.second_end.z);
    end

    always_comb begin
        prod_next.yz = qad_pkg::PROD_W'(a_reg.y) * qad_pkg::PROD_W'(b_reg.z);
        prod_next.zy = qad_pkg::PROD_W'(a_reg.z) * qad_pkg::PROD_W'(b_reg.y);
        prod_next.zx = qad_pkg::PROD_W'(a_reg.z) * qad_pkg::PROD_W'(b_reg.x);
        prod_next.xz = qad_pkg::PROD_W'(a_reg.x) * qad_pkg::PROD_W'(b_reg.z);
        prod_next.xy = qad_pkg::PROD_W'(a_reg.x) * qad_pkg::PROD_W'(b_reg.y);
        prod_next.yx = qad_pkg::PROD_W'(a_reg.y) * qad_pkg::PROD_W'(b_reg.x);
    end

    always_comb begin
        cross_next.x = qad_pkg::CROSS_W'(prod_reg.yz) - qad_pkg::CROSS_W'(prod_reg.zy);
        cross_next.y = qad_pkg::CROSS_W'(prod_reg.zx) - qad_pkg::CROSS_W'(prod_reg.xz);
        cross_next.z = qad_pkg::CROSS_W'(prod_reg.xy) - qad_pkg::CROSS_W'(prod_reg.yx);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg     <= a_next;
            b_reg     <= b_next;
            prod_reg  <= prod_next;
            cross_reg <= cross_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    assign out_valid = vld_reg[2];
    assign out_cross = cross_reg;

endmodule

// ===== hdl/qad_sqsum.sv =====
// Three-stage squared length: component magnitudes, squares, and their sum.
// Depends on qad_pkg for widths and the cross product type.
module qad_sqsum (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  qad_pkg::cross_t             in_cross,
    output logic                        out_valid,
    output logic [qad_pkg::SUM_W-1:0]   out_sum
);

    logic [qad_pkg::MAG_W-1:0] mx_reg, my_reg, mz_reg, mx_next, my_next, mz_next;
    logic [qad_pkg::SQ_W-1:0]  sx_reg, sy_reg, sz_reg, sx_next, sy_next, sz_next;
    logic [qad_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [2:0]                vld_reg;

    // The magnitude always fits MAG_W bits, so dropping the top two bits loses nothing.
    always_comb begin
        mx_next = qad_pkg::MAG_W'(in_cross.x[qad_pkg::CROSS_W-1] ? -in_cross.x : in_cross.x);
        my_next = qad_pkg::MAG_W'(in_cross.y[qad_pkg::CROSS_W-1] ? -in_cross.y : in_cross.y);
        mz_next = qad_pkg::MAG_W'(in_cross.z[qad_pkg::CROSS_W-1] ? -in_cross.z : in_cross.z);
        sx_next = qad_pkg::SQ_W'(mx_reg) * qad_pkg::SQ_W'(mx_reg);
        sy_next = qad_pkg::SQ_W'(my_reg) * qad_pkg::SQ_W'(my_reg);
        sz_next = qad_pkg::SQ_W'(mz_reg) * qad_pkg::SQ_W'(mz_reg);
        sum_next = qad_pkg::SUM_W'(sx_reg) + qad_pkg::SUM_W'(sy_reg) + qad_pkg::SUM_W'(sz_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mx_reg  <= mx_next;
            my_reg  <= my_next;
            mz_reg  <= mz_next;
            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
            sz_reg  <= sz_next;
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    assign out_valid = vld_reg[2];
    assign out_sum   = sum_reg;

endmodule

// ===== hdl/qad_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, restoring form.
// Depends on qad_pkg for the radicand, remainder and root widths.
module qad_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [qad_pkg::SUM_W-1:0]   rad_in,
    output logic                        out_valid,
    output logic [qad_pkg::ROOT_W-1:0]  root_out
);

    localparam int NSTAGE = qad_pkg::ROOT_W;
    localparam int WIDE_W = qad_pkg::ROOT_W + 3;

    logic [qad_pkg::SUM_W-1:0]  rad_reg  [NSTAGE];
    logic [qad_pkg::REM_W-1:0]  rem_reg  [NSTAGE];
    logic [qad_pkg::ROOT_W-1:0] root_reg [NSTAGE];
    logic [NSTAGE-1:0]          vld_reg;

    for (genvar i = 0; i < NSTAGE; i++) begin : g_stage
        logic [qad_pkg::SUM_W-1:0]  src_rad, rad_next;
        logic [qad_pkg::REM_W-1:0]  src_rem, rem_next;
        logic [qad_pkg::ROOT_W-1:0] src_root, root_next;
        logic                       src_vld;
        logic [WIDE_W-1:0]          shifted, trial;
        logic                       fits;

        if (i == 0) begin : g_first
            assign src_rad  = rad_in;
            assign src_rem  = '0;
            assign src_root = '0;
            assign src_vld  = in_valid;
        end else begin : g_chain
            assign src_rad  = rad_reg[i-1];
            assign src_rem  = rem_reg[i-1];
            assign src_root = root_reg[i-1];
            assign src_vld  = vld_reg[i-1];
        end

        // Bring down the next two radicand bits and try appending a one to the root.
        always_comb begin
            shifted   = {src_rem, src_rad[qad_pkg::SUM_W-1 -: 2]};
            trial     = WIDE_W'({src_root, 2'b01});
            fits      = (shifted >= trial);
            rem_next  = fits ? qad_pkg::REM_W'(shifted - trial) : qad_pkg::REM_W'(shifted);
            root_next = {src_root[qad_pkg::ROOT_W-2:0], fits};
            rad_next  = src_rad << 2;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[i]  <= rad_next;
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= src_vld;
            end
        end
    end

    assign out_valid = vld_reg[NSTAGE-1];
    assign root_out  = root_reg[NSTAGE-1];

endmodule

// ===== hdl/quad_area_from_diagonals.sv =====
// Top level of the quadrilateral area block: stream ports, pipeline chain, output register.
// Depends on qad_pkg, qad_cross, qad_sqsum and qad_sqrt.
//
// Channel   Direction  Ports                      Contents
// s_axis    in         tvalid, tready, tdata[191:0]  one quadrilateral request (12 coordinates)
// m_axis    out        tvalid, tready, tdata[39:0]   face area, 33 bits, zero padded
//
// Every request passes through 41 register stages: 3 for the cross product, 3 for the
// squared length, 34 for the square root (one root bit per stage) and the output register.
// With m_axis_tready high the block takes one request per cycle and returns one face per
// cycle. Reset clears only the valid bits; the data path needs no clearing.
// When a result sits unread in the output register and the last root stage holds another,
// the whole chain holds in place and s_axis_tready drops; nothing is lost or repeated.
module quad_area_from_diagonals (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // From bit 0 up, 16 bits each, signed Q7.8: first_start_x, first_start_y,
    // first_start_z, first_end_x, first_end_y, first_end_z, second_start_x,
    // second_start_y, second_start_z, second_end_x, second_end_y, second_end_z.
    input  logic [qad_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // From bit 0 up: face_area (33 bits, unsigned, units of 2^-16), then zero padding.
    output logic [qad_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    qad_pkg::quad_t                 quad;
    qad_pkg::cross_t                cross_vec;
    logic                           cross_valid;
    logic [qad_pkg::SUM_W-1:0]      sum_sq;
    logic                           sum_valid;
    logic [qad_pkg::ROOT_W-1:0]     root;
    logic                           root_valid;
    logic                           pipe_en;

    logic                           m_valid_reg;
    logic [qad_pkg::OUT_W-1:0]      m_area_reg;

    // The packed layout of quad_t matches the tdata field order bit for bit.
    assign quad = qad_pkg::quad_t'(s_axis_tdata);

    // The chain moves unless the last root stage holds a result that has nowhere to go.
    assign pipe_en       = !root_valid || !m_valid_reg || m_axis_tready;
    assign s_axis_tready = pipe_en;

    qad_cross u_cross (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s_axis_tvalid),
        .in_quad   (quad),
        .out_valid (cross_valid),
        .out_cross (cross_vec)
    );

    qad_sqsum u_sqsum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (cross_valid),
        .in_cross  (cross_vec),
        .out_valid (sum_valid),
        .out_sum   (sum_sq)
    );

    qad_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (sum_valid),
        .rad_in    (sum_sq),
        .out_valid (root_valid),
        .root_out  (root)
    );

    // Output register: halving the root is a drop of its lowest bit.
    always_ff @(posedge aclk) begin
        if (pipe_en && root_valid) begin
            m_area_reg <= root[qad_pkg::ROOT_W-1:1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en && root_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = qad_pkg::OUT_TDATA_W'(m_area_reg);

`ifndef ASSERT_OFF
    // The input side closes only while a result waits unread at the output.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a blocked result");

    // A new result appears only when the root pipeline delivered one.
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(root_valid))
        else $error("result shown with no finished root");

    // A finished root is never overwritten while the previous result is unread.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_axis_tready && root_valid) |=> (root_valid && m_valid_reg))
        else $error("finished root dropped during a stall");
`endif

endmodule
